// ===== hdl/sat_pkg.sv =====
// Shared types and constants for the shell argument tokenizer.
`default_nettype none

package sat_pkg;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_ARG_END = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_EMPTY_LINE   = 2'd1,
        ERR_OPEN_DOUBLE  = 2'd2,
        ERR_OPEN_SINGLE  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_DOUBLE = 2'd1,
        QM_SINGLE = 2'd2,
        QM_SPARE  = 2'd3
    } qmode_t;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SEP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_D     = 3'd4;

    localparam logic [2:0] RST_SEP_COUNT = 3'd3;
    localparam logic [7:0] RST_SEP_A     = 8'd32;
    localparam logic [7:0] RST_SEP_B     = 8'd9;
    localparam logic [7:0] RST_SEP_C     = 8'd10;
    localparam logic [7:0] RST_SEP_D     = 8'd0;

    typedef struct packed {
        logic [2:0]      sep_count;
        logic [3:0][7:0] sep;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/shell_argument_tokenizer.sv =====
// Top level of the shell argument tokenizer: configuration and stream ports.
// Usage:
// Line bytes arrive one per beat on the s_ channel; byte 0 ends the line.
// Each beat yields zero, one or two result beats on the m_ channel: data
// bytes, argument ends, and at end of line either a done beat with the
// argument and byte counts or an error beat. m_tlast marks the final
// result caused by an input beat, m_tuser carries the result kind.
// An input beat is decoded in the cycle it is accepted and its results
// are registered in the result queue before they reach m_. Throughput is
// one byte per cycle while s_tready is high; a beat that yields two results
// holds s_tready low while the three-entry queue, the only limit, drains.
// When the receiver stalls, results collect in the queue and s_tready
// drops as soon as fewer than two entries are free.
// Reset empties the queue, clears the line state and loads the default
// separators (space, tab, newline). The user must write registers through
// the cfg_ port only while the block is idle; the block does not enforce it.
`default_nettype none

module shell_argument_tokenizer #(
    parameter  int MAX_LINE = 4096,
    localparam int COL_W    = $clog2(MAX_LINE + 1),
    localparam int BYTE_W   = $clog2(2 * MAX_LINE + 1),
    localparam int FIELD_W  = 8 + 2 + COL_W + COL_W + BYTE_W,
    localparam int TDATA_W  = ((FIELD_W + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wen,
    input  wire logic [sat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // character
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_byte, fault_code, error_column, argument_total, byte_total, zero fill
    output logic [TDATA_W-1:0]                 m_tdata,
    output logic [1:0]                         m_tuser,   // kind
    output logic                               m_tlast
);

    import sat_pkg::*;

    localparam int RES_W = FIELD_W + 3;

    cfg_t             cfg_reg;
    logic             in_fire;
    logic [1:0]       res_count;
    logic [RES_W-1:0] res0;
    logic [RES_W-1:0] res1;
    logic [RES_W-1:0] head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sep_count <= RST_SEP_COUNT;
            cfg_reg.sep[0]    <= RST_SEP_A;
            cfg_reg.sep[1]    <= RST_SEP_B;
            cfg_reg.sep[2]    <= RST_SEP_C;
            cfg_reg.sep[3]    <= RST_SEP_D;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_SEP_COUNT: cfg_reg.sep_count <= cfg_wdata[2:0];
                REG_SEP_A:     cfg_reg.sep[0]    <= cfg_wdata;
                REG_SEP_B:     cfg_reg.sep[1]    <= cfg_wdata;
                REG_SEP_C:     cfg_reg.sep[2]    <= cfg_wdata;
                REG_SEP_D:     cfg_reg.sep[3]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_fire = s_tvalid && s_tready;

    sat_core #(
        .MAX_LINE (MAX_LINE)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_char   (s_tdata),
        .cfg       (cfg_reg),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    sat_result_queue #(
        .WIDTH (RES_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .can_push   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_head   (head)
    );

    assign m_tlast = head[0];
    assign m_tuser = head[2:1];
    assign m_tdata = TDATA_W'(head[RES_W-1:3]);

endmodule

`default_nettype wire

// ===== hdl/sat_result_queue.sv =====
// Three-entry result queue that takes up to two results per cycle.
`default_nettype none

module sat_result_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [1:0]       push_count,
    input  wire logic [WIDTH-1:0] push0,
    input  wire logic [WIDTH-1:0] push1,
    output logic                  can_push,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_head
);

    logic [WIDTH-1:0] q_reg [3];
    logic [WIDTH-1:0] q_next [3];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [1:0]       count_pop;
    logic             pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_head  = q_reg[0];
    // Room for two results is judged from the registered count alone.
    assign can_push  = (count_reg <= 2'd1);
    assign pop       = out_valid && out_ready;
    assign count_pop = count_reg - {1'b0, pop};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (pop && i < 2) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push_count != 2'd0 && 2'(i) == count_pop) begin
                q_next[i] = push0;
            end
            if (push_count == 2'd2 && 2'(i) == count_pop + 2'd1) begin
                q_next[i] = push1;
            end
        end
        count_next = count_pop + push_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3 || !(push_count != 2'd0 && !pop))
        else $error("result queue overflow");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_count != 2'd0 |-> count_reg <= 2'd1)
        else $error("results pushed without room");
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push_count != 2'd3)
        else $error("more than two results from one beat");

endmodule

`default_nettype wire

// ===== hdl/sat_core.sv =====
// Tokenizer state and the per-byte decision logic.
`default_nettype none

module sat_core #(
    parameter  int MAX_LINE = 4096,
    localparam int COL_W    = $clog2(MAX_LINE + 1),
    localparam int BYTE_W   = $clog2(2 * MAX_LINE + 1),
    localparam int FIELD_W  = 8 + 2 + COL_W + COL_W + BYTE_W,
    localparam int RES_W    = FIELD_W + 3
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire logic [7:0]       in_char,
    input  wire sat_pkg::cfg_t    cfg,
    output logic [1:0]            res_count,
    output logic [RES_W-1:0]      res0,
    output logic [RES_W-1:0]      res1
);

    import sat_pkg::*;

    localparam logic [COL_W-1:0]  COL_CAP  = COL_W'(MAX_LINE);
    localparam logic [BYTE_W-1:0] BYTE_CAP = BYTE_W'(2 * MAX_LINE);

    logic              in_arg_reg, in_arg_next;
    qmode_t            qm_reg, qm_next;
    logic              pb_reg, pb_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  qcol_reg, qcol_next;
    logic [COL_W-1:0]  argc_reg, argc_next;
    logic [BYTE_W-1:0] bytec_reg, bytec_next;

    logic              first;
    logic              is_sep;
    logic              start;
    logic              end_req;
    logic              emit_bsl;
    logic              emit_c;
    logic              arg_end;
    logic              fin;
    logic              done;
    kind_t             fin_kind;
    err_t              fin_code;
    logic [COL_W-1:0]  fin_col;
    logic [1:0]        bumps;
    logic [BYTE_W:0]   byte_sum;
    logic [BYTE_W-1:0] bytec_sat;
    logic [RES_W-1:0]  r_bsl, r_char, r_end, r_fin;

    function automatic logic [RES_W-1:0] pack_res(
        input kind_t             kind,
        input logic [7:0]        b,
        input err_t              code,
        input logic [COL_W-1:0]  col,
        input logic [COL_W-1:0]  args,
        input logic [BYTE_W-1:0] bytes,
        input logic              last
    );
        return {bytes, args, col, code, b, kind, last};
    endfunction

    // Byte 0 always splits; the registers beyond the configured count are ignored.
    always_comb begin
        is_sep = (in_char == CH_NUL);
        if (cfg.sep_count >= 3'd1 && in_char == cfg.sep[0]) is_sep = 1'b1;
        if (cfg.sep_count >= 3'd2 && in_char == cfg.sep[1]) is_sep = 1'b1;
        if (cfg.sep_count >= 3'd3 && in_char == cfg.sep[2]) is_sep = 1'b1;
        if (cfg.sep_count >= 3'd4 && in_char == cfg.sep[3]) is_sep = 1'b1;
    end

    always_comb begin
        first    = (col_reg == '0);
        col_next = (col_reg < COL_CAP) ? col_reg + 1'b1 : col_reg;
        qm_next  = qm_reg;
        pb_next  = pb_reg;
        qcol_next = qcol_reg;
        start    = 1'b0;
        end_req  = 1'b0;
        emit_bsl = 1'b0;
        emit_c   = 1'b0;
        fin      = 1'b0;
        done     = 1'b0;
        fin_kind = KIND_ERROR;
        fin_code = ERR_NONE;
        fin_col  = '0;
        case (qm_reg)
            QM_DOUBLE: begin
                if (pb_reg) begin
                    pb_next = 1'b0;
                    if (in_char == CH_DQ) begin
                        emit_c = 1'b1;
                    end else if (in_char == CH_NUL) begin
                        fin      = 1'b1;
                        fin_code = ERR_OPEN_DOUBLE;
                        fin_col  = qcol_reg;
                    end else begin
                        emit_bsl = 1'b1;
                        emit_c   = 1'b1;
                    end
                end else if (in_char == CH_DQ) begin
                    qm_next = QM_NONE;
                end else if (in_char == CH_NUL) begin
                    fin      = 1'b1;
                    fin_code = ERR_OPEN_DOUBLE;
                    fin_col  = qcol_reg;
                end else if (in_char == CH_BSL) begin
                    pb_next = 1'b1;
                end else begin
                    emit_c = 1'b1;
                end
            end
            QM_SINGLE: begin
                if (in_char == CH_SQ) begin
                    qm_next = QM_NONE;
                end else if (in_char == CH_NUL) begin
                    fin      = 1'b1;
                    fin_code = ERR_OPEN_SINGLE;
                    fin_col  = qcol_reg;
                end else begin
                    emit_c = 1'b1;
                end
            end
            default: begin
                if (pb_reg) begin
                    pb_next = 1'b0;
                    if (in_char == CH_NUL) begin
                        end_req = 1'b1;
                        done    = 1'b1;
                    end else if (in_char == CH_DQ || in_char == CH_SQ || is_sep) begin
                        emit_c = 1'b1;
                    end else begin
                        emit_bsl = 1'b1;
                        emit_c   = 1'b1;
                    end
                end else if (is_sep) begin
                    end_req = 1'b1;
                    done    = (in_char == CH_NUL);
                end else begin
                    start = 1'b1;
                    if (in_char == CH_BSL) begin
                        pb_next = 1'b1;
                    end else if (in_char == CH_DQ) begin
                        qm_next   = QM_DOUBLE;
                        qcol_next = col_next;
                    end else if (in_char == CH_SQ) begin
                        qm_next   = QM_SINGLE;
                        qcol_next = col_next;
                    end else begin
                        emit_c = 1'b1;
                    end
                end
                if (done) begin
                    fin = 1'b1;
                    if (first) begin
                        fin_code = ERR_EMPTY_LINE;
                    end else begin
                        fin_kind = KIND_DONE;
                    end
                end
            end
        endcase
    end

    always_comb begin
        arg_end     = end_req && in_arg_reg;
        in_arg_next = start ? 1'b1 : (end_req ? 1'b0 : in_arg_reg);
        argc_next   = (start && !in_arg_reg && argc_reg < COL_CAP) ? argc_reg + 1'b1
                                                                    : argc_reg;
        bumps       = 2'({1'b0, emit_bsl} + {1'b0, emit_c} + {1'b0, arg_end});
        byte_sum    = {1'b0, bytec_reg} + (BYTE_W + 1)'(bumps);
        bytec_sat   = (byte_sum > {1'b0, BYTE_CAP}) ? BYTE_CAP : byte_sum[BYTE_W-1:0];
        bytec_next  = bytec_sat;

        r_bsl  = pack_res(KIND_DATA, CH_BSL, ERR_NONE, '0, '0, '0, 1'b0);
        r_char = pack_res(KIND_DATA, in_char, ERR_NONE, '0, '0, '0, 1'b1);
        r_end  = pack_res(KIND_ARG_END, 8'd0, ERR_NONE, '0, '0, '0, !fin);
        if (fin_kind == KIND_DONE) begin
            r_fin = pack_res(KIND_DONE, 8'd0, ERR_NONE, '0, argc_reg, bytec_sat, 1'b1);
        end else begin
            r_fin = pack_res(KIND_ERROR, 8'd0, fin_code, fin_col, '0, '0, 1'b1);
        end

        res0      = r_fin;
        res1      = r_fin;
        res_count = 2'd0;
        if (emit_bsl) begin
            res0      = r_bsl;
            res1      = r_char;
            res_count = 2'd2;
        end else if (emit_c) begin
            res0      = r_char;
            res_count = 2'd1;
        end else if (arg_end) begin
            res0      = r_end;
            res_count = fin ? 2'd2 : 2'd1;
        end else if (fin) begin
            res_count = 2'd1;
        end
        if (!in_fire) begin
            res_count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_arg_reg <= 1'b0;
            qm_reg     <= QM_NONE;
            pb_reg     <= 1'b0;
            col_reg    <= '0;
            qcol_reg   <= '0;
            argc_reg   <= '0;
            bytec_reg  <= '0;
        end else if (in_fire) begin
            if (fin) begin
                // End of line or error: the whole line context starts afresh.
                in_arg_reg <= 1'b0;
                qm_reg     <= QM_NONE;
                pb_reg     <= 1'b0;
                col_reg    <= '0;
                qcol_reg   <= '0;
                argc_reg   <= '0;
                bytec_reg  <= '0;
            end else begin
                in_arg_reg <= in_arg_next;
                qm_reg     <= qm_next;
                pb_reg     <= pb_next;
                col_reg    <= col_next;
                qcol_reg   <= qcol_next;
                argc_reg   <= argc_next;
                bytec_reg  <= bytec_next;
            end
        end
    end

    a_line_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && fin |=> col_reg == '0 && argc_reg == '0 && bytec_reg == '0)
        else $error("line state not cleared after final result");
    a_quote_in_arg: assert property (@(posedge aclk) disable iff (!aresetn)
        qm_reg != QM_NONE |-> in_arg_reg)
        else $error("quote open outside an argument");
    a_no_bsl_single: assert property (@(posedge aclk) disable iff (!aresetn)
        pb_reg |-> qm_reg != QM_SINGLE)
        else $error("pending backslash inside single quotes");

endmodule

`default_nettype wire
